FILE: rtl/wbi_pkg.sv
// ----------------------------------------------------------------------------
// wbi_pkg
// Shared sizes and codes of the write-back block index.
// ----------------------------------------------------------------------------
package wbi_pkg;

  localparam int SLOTS     = 1024;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int LINK_W    = IDX_W + 1;
  localparam int MAX_BATCH = 64;
  localparam int BIDX_W    = $clog2(MAX_BATCH);
  localparam int BCNT_W    = $clog2(MAX_BATCH + 1);
  localparam int ADDR_W    = 40;
  localparam int RANGE_W   = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 3;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
  localparam logic [OP_W-1:0] OP_GATHER  = 3'd2;
  localparam logic [OP_W-1:0] OP_OK      = 3'd3;
  localparam logic [OP_W-1:0] OP_FAIL    = 3'd4;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ERROR   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_SEQ_ERR = 3'd5;

endpackage

FILE: rtl/wbi_ram.sv
// ----------------------------------------------------------------------------
// wbi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/write_back_block_index_top.sv
// ----------------------------------------------------------------------------
// write_back_block_index_top
// Tag and order engine of a write-back block cache: hashed bucket chains,
// allocation FIFO, free list and drain batches, all held in linked RAMs.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and results come
// back on out_valid pulses that the receiver must take as they come. After
// reset all bucket heads are swept to null, one per cycle, with busy high.
// Error and sequence answers to a refused request come straight from idle.
// Write and lookup read the bucket head and walk its chain entry by entry;
// a fresh allocation then passes S_AL1 and S_AL2. A gather reads the tag of
// the FIFO head and walks the chain of each next block. Complete ok steps
// S_CB, S_CL, S_LUSE per batch slot, complete fail S_CB and S_CL, and discard
// S_LREAD and S_LUSE per FIFO entry; the registered link RAMs are walked.
module write_back_block_index_top
  import wbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ADDR_W-1:0]  in_block_addr,
  input  logic [RANGE_W-1:0] in_range_blocks,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [IDX_W-1:0]   out_slot_index,
  output logic [ADDR_W-1:0]  out_slot_block,
  output logic               out_new_slot,
  output logic               out_last,
  output logic [LINK_W-1:0]  out_pending_count,
  output logic [LINK_W-1:0]  out_retired_count
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_HEADW, S_WALK, S_DEC, S_AL1, S_AL2,
    S_GB, S_GB2, S_GADD, S_GEND, S_CB, S_CL, S_LREAD, S_LUSE
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ADDR_W-1:0]  tgt_r, tgt_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [LINK_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0]  found_r, found_nxt;
  logic               fbusy_r, fbusy_nxt;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [BCNT_W-1:0]  n_r, n_nxt;
  logic [LINK_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic [ADDR_W-1:0]  pblk_r, pblk_nxt;
  logic               pv_r, pv_nxt;
  logic [LINK_W-1:0]  fhead_r, fhead_nxt;
  logic [LINK_W-1:0]  ftail_r, ftail_nxt;
  logic [LINK_W-1:0]  free_r, free_nxt;
  logic [LINK_W-1:0]  fresh_r, fresh_nxt;
  logic [LINK_W-1:0]  occ_r, occ_nxt;
  logic               err_r, err_nxt;
  logic [BCNT_W-1:0]  bsize_r, bsize_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               fail_r, fail_nxt;

  logic               ov_r, ov_nxt;
  logic [STAT_W-1:0]  ost_r, ost_nxt;
  logic [IDX_W-1:0]   oidx_r, oidx_nxt;
  logic [ADDR_W-1:0]  oblk_r, oblk_nxt;
  logic               onew_r, onew_nxt;
  logic               olast_r, olast_nxt;
  logic [LINK_W-1:0]  opend_r;
  logic [LINK_W-1:0]  oret_r, oret_nxt;

  // ram ports
  logic [IDX_W-1:0]   sl_ra, bh_ra;
  logic [ADDR_W-1:0]  tag_rd, tag_wd;
  logic [LINK_W-1:0]  cn_rd, cp_rd, fn_rd, fp_rd, fl_rd, bh_rd;
  logic               bz_rd;
  logic [IDX_W-1:0]   bl_rd;
  logic               tag_we, cn_we, cp_we, fn_we, fp_we, fl_we, bz_we, bh_we, bl_we;
  logic [IDX_W-1:0]   tag_wa, cn_wa, cp_wa, fn_wa, fp_wa, fl_wa, bz_wa, bh_wa;
  logic [LINK_W-1:0]  cn_wd, cp_wd, fn_wd, fp_wd, fl_wd, bh_wd;
  logic               bz_wd;
  logic [BIDX_W-1:0]  bl_wa;
  logic [IDX_W-1:0]   bl_wd;

  logic               match;
  logic [ADDR_W-1:0]  diff;
  logic               in_rng;
  logic [IDX_W-1:0]   cur_i;

  assign busy   = (state_r != S_IDLE);
  assign match  = (tag_rd == tgt_r);
  assign diff   = tag_rd - tgt_r;
  assign in_rng = (tag_rd >= tgt_r) && (diff < {{(ADDR_W-RANGE_W){1'b0}}, range_r});
  assign cur_i  = cur_r[IDX_W-1:0];

  wbi_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(sl_ra), .rdata(tag_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_cn (
    .clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(sl_ra), .rdata(cn_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_cp (
    .clk(clk), .we(cp_we), .waddr(cp_wa), .wdata(cp_wd), .raddr(sl_ra), .rdata(cp_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_fn (
    .clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(sl_ra), .rdata(fn_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_fp (
    .clk(clk), .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(sl_ra), .rdata(fp_rd));
  wbi_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_bz (
    .clk(clk), .we(bz_we), .waddr(bz_wa), .wdata(bz_wd), .raddr(sl_ra), .rdata(bz_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
    .raddr(free_r[IDX_W-1:0]), .rdata(fl_rd));
  wbi_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_bh (
    .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));
  wbi_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BATCH)) u_bl (
    .clk(clk), .we(bl_we), .waddr(bl_wa), .wdata(bl_wd),
    .raddr(n_r[BIDX_W-1:0]), .rdata(bl_rd));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tgt_nxt   = tgt_r;
    range_nxt = range_r;
    cur_nxt   = cur_r;
    found_nxt = found_r;
    fbusy_nxt = fbusy_r;
    head_nxt  = head_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    pidx_nxt  = pidx_r;
    pblk_nxt  = pblk_r;
    pv_nxt    = pv_r;
    fhead_nxt = fhead_r;
    ftail_nxt = ftail_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    occ_nxt   = occ_r;
    err_nxt   = err_r;
    bsize_nxt = bsize_r;
    clr_nxt   = clr_r;
    fail_nxt  = fail_r;

    ov_nxt    = 1'b0;
    ost_nxt   = ST_OK;
    oidx_nxt  = '0;
    oblk_nxt  = '0;
    onew_nxt  = 1'b0;
    olast_nxt = 1'b1;
    oret_nxt  = '0;

    sl_ra = cur_i;
    bh_ra = tgt_r[IDX_W-1:0];

    tag_we = 1'b0; tag_wa = cur_i; tag_wd = tgt_r;
    cn_we  = 1'b0; cn_wa  = cur_i; cn_wd  = head_r;
    cp_we  = 1'b0; cp_wa  = cur_i; cp_wd  = NIL;
    fn_we  = 1'b0; fn_wa  = cur_i; fn_wd  = NIL;
    fp_we  = 1'b0; fp_wa  = cur_i; fp_wd  = ftail_r;
    fl_we  = 1'b0; fl_wa  = cur_i; fl_wd  = free_r;
    bz_we  = 1'b0; bz_wa  = cur_i; bz_wd  = 1'b0;
    bh_we  = 1'b0; bh_wa  = tgt_r[IDX_W-1:0]; bh_wd = cur_r;
    bl_we  = 1'b0; bl_wa  = n_r[BIDX_W-1:0]; bl_wd = cur_i;

    case (state_r)
      S_CLR: begin
        bh_we   = 1'b1;
        bh_wa   = clr_r;
        bh_wd   = NIL;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          tgt_nxt   = in_block_addr;
          range_nxt = in_range_blocks;
          found_nxt = NIL;
          fbusy_nxt = 1'b0;
          n_nxt     = '0;
          cnt_nxt   = '0;
          pv_nxt    = 1'b0;
          case (in_operation)
            OP_WRITE, OP_LOOKUP: begin
              if (err_r) begin
                ov_nxt   = 1'b1;
                ost_nxt  = ST_ERROR;
                oblk_nxt = in_block_addr;
              end else begin
                state_nxt = S_HEAD;
              end
            end
            OP_GATHER: begin
              if (bsize_r != '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_SEQ_ERR;
              end else if (err_r) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_ERROR;
              end else if (occ_r == '0 || fhead_r == NIL) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_NONE;
              end else begin
                cur_nxt   = fhead_r;
                state_nxt = S_GB;
              end
            end
            OP_OK, OP_FAIL: begin
              if (bsize_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_SEQ_ERR;
              end else begin
                fail_nxt  = (in_operation == OP_FAIL);
                state_nxt = S_CB;
              end
            end
            OP_DISCARD: begin
              if (bsize_r != '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_SEQ_ERR;
              end else if (err_r) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_ERROR;
              end else if (fhead_r == NIL) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_OK;
              end else begin
                cur_nxt   = fhead_r;
                state_nxt = S_LREAD;
              end
            end
            OP_CLEAR: begin
              err_nxt = 1'b0;
              ov_nxt  = 1'b1;
              ost_nxt = ST_OK;
            end
            default: begin
              ov_nxt  = 1'b1;
              ost_nxt = ST_SEQ_ERR;
            end
          endcase
        end
      end

      S_HEAD: begin
        state_nxt = S_HEADW;
      end

      S_HEADW: begin
        head_nxt = bh_rd;
        if (bh_rd == NIL) begin
          state_nxt = S_DEC;
        end else begin
          sl_ra     = bh_rd[IDX_W-1:0];
          cur_nxt   = bh_rd;
          state_nxt = S_WALK;
        end
      end

      // newest first: stop at first match; gather keeps the last match
      S_WALK: begin
        if (op_r != OP_GATHER && match) begin
          found_nxt = cur_r;
          fbusy_nxt = bz_rd;
          state_nxt = S_DEC;
        end else begin
          if (match) begin
            found_nxt = cur_r;
          end
          if (cn_rd == NIL) begin
            state_nxt = S_DEC;
          end else begin
            sl_ra   = cn_rd[IDX_W-1:0];
            cur_nxt = cn_rd;
          end
        end
      end

      S_DEC: begin
        case (op_r)
          OP_LOOKUP: begin
            ov_nxt    = 1'b1;
            oblk_nxt  = tgt_r;
            state_nxt = S_IDLE;
            if (found_r != NIL) begin
              oidx_nxt = found_r[IDX_W-1:0];
            end else begin
              ost_nxt = ST_MISS;
            end
          end
          OP_GATHER: begin
            if (found_r != NIL) begin
              cur_nxt   = found_r;
              state_nxt = S_GADD;
            end else begin
              state_nxt = S_GEND;
            end
          end
          default: begin
            if (found_r != NIL && !fbusy_r) begin
              ov_nxt    = 1'b1;
              oidx_nxt  = found_r[IDX_W-1:0];
              oblk_nxt  = tgt_r;
              state_nxt = S_IDLE;
            end else if (occ_r >= LINK_W'(SLOTS) || free_r == NIL) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_FULL;
              oblk_nxt  = tgt_r;
              state_nxt = S_IDLE;
            end else begin
              cur_nxt   = free_r;
              state_nxt = S_AL1;
            end
          end
        endcase
      end

      S_AL1: begin
        tag_we = 1'b1;
        fp_we  = 1'b1;
        fn_we  = 1'b1;
        bz_we  = 1'b1;
        cp_we  = 1'b1;
        cn_we  = 1'b1;
        bh_we  = 1'b1;
        state_nxt = S_AL2;
      end

      S_AL2: begin
        if (ftail_r != NIL) begin
          fn_we = 1'b1;
          fn_wa = ftail_r[IDX_W-1:0];
          fn_wd = cur_r;
        end else begin
          fhead_nxt = cur_r;
        end
        if (head_r != NIL) begin
          cp_we = 1'b1;
          cp_wa = head_r[IDX_W-1:0];
          cp_wd = cur_r;
        end
        ftail_nxt = cur_r;
        occ_nxt   = occ_r + 1'b1;
        if (cur_r >= fresh_r) begin
          free_nxt  = cur_r + 1'b1;
          fresh_nxt = cur_r + 1'b1;
        end else begin
          free_nxt = fl_rd;
        end
        ov_nxt    = 1'b1;
        oidx_nxt  = cur_i;
        oblk_nxt  = tgt_r;
        onew_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end

      S_GB: begin
        state_nxt = S_GB2;
      end

      S_GB2: begin
        tgt_nxt   = tag_rd;
        state_nxt = S_GADD;
      end

      // the previous slot goes out once it is known not to be the last
      S_GADD: begin
        bl_we  = 1'b1;
        bz_we  = 1'b1;
        bz_wd  = 1'b1;
        if (pv_r) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = pidx_r;
          oblk_nxt  = pblk_r;
          olast_nxt = 1'b0;
        end
        pidx_nxt  = cur_i;
        pblk_nxt  = tgt_r;
        pv_nxt    = 1'b1;
        n_nxt     = n_r + 1'b1;
        found_nxt = NIL;
        if (n_r == BCNT_W'(MAX_BATCH - 1)) begin
          state_nxt = S_GEND;
        end else begin
          tgt_nxt   = tgt_r + 1'b1;
          state_nxt = S_HEAD;
        end
      end

      S_GEND: begin
        ov_nxt    = 1'b1;
        oidx_nxt  = pidx_r;
        oblk_nxt  = pblk_r;
        bsize_nxt = n_r;
        state_nxt = S_IDLE;
      end

      S_CB: begin
        state_nxt = S_CL;
      end

      S_CL: begin
        if (fail_r) begin
          bz_we = 1'b1;
          bz_wa = bl_rd;
          n_nxt = n_r + 1'b1;
          if (n_r + 1'b1 == bsize_r) begin
            err_nxt   = 1'b1;
            bsize_nxt = '0;
            ov_nxt    = 1'b1;
            ost_nxt   = ST_ERROR;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CB;
          end
        end else begin
          sl_ra     = bl_rd;
          cur_nxt   = {1'b0, bl_rd};
          state_nxt = S_LUSE;
        end
      end

      S_LREAD: begin
        state_nxt = S_LUSE;
      end

      // unlink one slot (ok, or discard in range) from its chain and the fifo, push it on the free list
      S_LUSE: begin
        if (op_r == OP_OK || in_rng) begin
          if (cp_rd != NIL) begin
            cn_we = 1'b1;
            cn_wa = cp_rd[IDX_W-1:0];
            cn_wd = cn_rd;
          end else begin
            bh_we = 1'b1;
            bh_wa = tag_rd[IDX_W-1:0];
            bh_wd = cn_rd;
          end
          if (cn_rd != NIL) begin
            cp_we = 1'b1;
            cp_wa = cn_rd[IDX_W-1:0];
            cp_wd = cp_rd;
          end
          if (fp_rd != NIL) begin
            fn_we = 1'b1;
            fn_wa = fp_rd[IDX_W-1:0];
            fn_wd = fn_rd;
          end else begin
            fhead_nxt = fn_rd;
          end
          if (fn_rd != NIL) begin
            fp_we = 1'b1;
            fp_wa = fn_rd[IDX_W-1:0];
            fp_wd = fp_rd;
          end else begin
            ftail_nxt = fp_rd;
          end
          bz_we    = 1'b1;
          fl_we    = 1'b1;
          free_nxt = cur_r;
          if (occ_r != '0) begin
            occ_nxt = occ_r - 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        if (op_r == OP_OK) begin
          n_nxt = n_r + 1'b1;
          if (n_r + 1'b1 == bsize_r) begin
            bsize_nxt = '0;
            ov_nxt    = 1'b1;
            oret_nxt  = cnt_nxt;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CB;
          end
        end else if (fn_rd == NIL) begin
          ov_nxt    = 1'b1;
          oret_nxt  = cnt_nxt;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = fn_rd;
          state_nxt = S_LREAD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      fhead_r <= NIL;
      ftail_r <= NIL;
      free_r  <= '0;
      fresh_r <= '0;
      occ_r   <= '0;
      err_r   <= 1'b0;
      bsize_r <= '0;
      pv_r    <= 1'b0;
      fail_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fhead_r <= fhead_nxt;
      ftail_r <= ftail_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      occ_r   <= occ_nxt;
      err_r   <= err_nxt;
      bsize_r <= bsize_nxt;
      pv_r    <= pv_nxt;
      fail_r  <= fail_nxt;
      ov_r    <= ov_nxt;
    end
    op_r    <= op_nxt;
    tgt_r   <= tgt_nxt;
    range_r <= range_nxt;
    cur_r   <= cur_nxt;
    found_r <= found_nxt;
    fbusy_r <= fbusy_nxt;
    head_r  <= head_nxt;
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    pidx_r  <= pidx_nxt;
    pblk_r  <= pblk_nxt;
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
    oblk_r  <= oblk_nxt;
    onew_r  <= onew_nxt;
    olast_r <= olast_nxt;
    opend_r <= occ_nxt;
    oret_r  <= oret_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_slot_index    = oidx_r;
  assign out_slot_block    = oblk_r;
  assign out_new_slot      = onew_r;
  assign out_last          = olast_r;
  assign out_pending_count = opend_r;
  assign out_retired_count = oret_r;

endmodule
